// ----- hdl/tdc_pkg.sv -----
// ----------------------------------------------------------------------------
// Thermistor divider conversion package
// Shared widths, register indexes, status codes and types.
// ----------------------------------------------------------------------------
`default_nettype none

package tdc_pkg;

  localparam int unsigned RES_WIDTH       = 32;
  localparam int unsigned ADC_WIDTH       = 16;
  localparam int unsigned CFG_INDEX_WIDTH = 3;
  localparam int unsigned CFG_DATA_WIDTH  = 32;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SERIES     = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PARALLEL   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SUPPLY     = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ADC_REF    = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FULL_SCALE = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_SAT     = 2'd2;

  localparam logic CMD_RES_FROM_CODE = 1'b0;
  localparam logic CMD_CODE_FROM_RES = 1'b1;

  typedef struct packed {
    logic [31:0] series;
    logic [31:0] parallel;
    logic [15:0] supply;
    logic [15:0] adc_ref;
    logic [15:0] full_scale;
  } cfg_t;

  typedef struct packed {
    logic cmd;
    logic inv;
    logic sat;
  } flags_t;

endpackage

`default_nettype wire

// ----- hdl/tdc_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, N stages, a new request can enter every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_div #(
  parameter int unsigned N  = 64,
  parameter int unsigned D  = 33,
  parameter int unsigned SW = 3
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [N-1:0]  dividend_i,
  input  wire logic [D-1:0]  divisor_i,
  input  wire logic [SW-1:0] side_i,
  output logic               out_valid_o,
  output logic [N-1:0]       quotient_o,
  output logic [SW-1:0]      side_o
);

  logic [N-1:0]  vld_q;
  logic [N-1:0]  dvd_q [N];
  logic [D-1:0]  rem_q [N];
  logic [D-1:0]  dsr_q [N];
  logic [SW-1:0] side_q [N];

  logic [N-1:0]  vld_in;
  logic [N-1:0]  dvd_in [N];
  logic [D-1:0]  rem_in [N];
  logic [D-1:0]  dsr_in [N];
  logic [SW-1:0] side_in [N];

  logic [N-1:0]  dvd_d [N];
  logic [D-1:0]  rem_d [N];

  always_comb begin
    vld_in[0]  = in_valid_i;
    dvd_in[0]  = dividend_i;
    rem_in[0]  = '0;
    dsr_in[0]  = divisor_i;
    side_in[0] = side_i;
    for (int k = 1; k < N; k++) begin
      vld_in[k]  = vld_q[k-1];
      dvd_in[k]  = dvd_q[k-1];
      rem_in[k]  = rem_q[k-1];
      dsr_in[k]  = dsr_q[k-1];
      side_in[k] = side_q[k-1];
    end
  end

  always_comb begin
    logic [D:0] trial;
    logic       take;
    trial = '0;
    take  = 1'b0;
    for (int k = 0; k < N; k++) begin
      trial    = {rem_in[k], dvd_in[k][N-1]};
      take     = (trial >= {1'b0, dsr_in[k]});
      dvd_d[k] = {dvd_in[k][N-2:0], take};
      rem_d[k] = take ? D'(trial - {1'b0, dsr_in[k]}) : trial[D-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_in;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      dvd_q[k]  <= dvd_d[k];
      rem_q[k]  <= rem_d[k];
      dsr_q[k]  <= dsr_in[k];
      side_q[k] <= side_in[k];
    end
  end

  assign out_valid_o = vld_q[N-1];
  assign quotient_o  = dvd_q[N-1];
  assign side_o      = side_q[N-1];

endmodule

`default_nettype wire

// ----- hdl/tdc_front.sv -----
// ----------------------------------------------------------------------------
// Front end of the conversion pipeline
// Forms the first dividend and divisor for both commands over two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_front #(
  parameter int unsigned RW = 32,
  parameter int unsigned AW = 16,
  parameter int unsigned N1 = 64,
  parameter int unsigned D1 = 33
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tdc_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  input  wire logic          cmd_i,
  input  wire logic [AW-1:0] code_i,
  input  wire logic [RW-1:0] res_i,
  output logic               out_valid_o,
  output logic [N1-1:0]      dividend_o,
  output logic [D1-1:0]      divisor_o,
  output tdc_pkg::flags_t    flags_o
);

  logic [RW-1:0] series;
  logic [RW-1:0] parallel;
  assign series   = cfg_i.series[RW-1:0];
  assign parallel = cfg_i.parallel[RW-1:0];

  logic               v1_q;
  logic               cmd1_q;
  logic [AW-1:0]      code1_q;
  logic [RW-1:0]      r1_q;
  logic [RW+15:0]     sr1_q;
  logic [AW+15:0]     used1_q;
  logic [2*RW-1:0]    pr1_q;
  logic [RW:0]        ps1_q;
  logic               pnz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd1_q  <= cmd_i;
    code1_q <= code_i;
    r1_q    <= res_i;
    sr1_q   <= (RW+16)'(series) * (RW+16)'(cfg_i.adc_ref);
    used1_q <= (AW+16)'(cfg_i.adc_ref) * (AW+16)'(code_i);
    pr1_q   <= (2*RW)'(parallel) * (2*RW)'(res_i);
    ps1_q   <= (RW+1)'(parallel) + (RW+1)'(res_i);
    pnz1_q  <= (parallel != '0);
  end

  logic [RW+AW+15:0] num0;
  logic [31:0]       top;
  logic [32:0]       den0;
  logic              inv0;
  logic [N1-1:0]     dividend_d;
  logic [D1-1:0]     divisor_d;
  tdc_pkg::flags_t   flags_d;

  always_comb begin
    num0 = (RW+AW+16)'(sr1_q) * (RW+AW+16)'(code1_q);
    top  = 32'(cfg_i.supply) * 32'(cfg_i.full_scale);
    den0 = {1'b0, top} - 33'(used1_q);
    inv0 = den0[32] || (den0 == '0);
    flags_d.cmd = cmd1_q;
    flags_d.sat = 1'b0;
    if (cmd1_q == tdc_pkg::CMD_RES_FROM_CODE) begin
      flags_d.inv = inv0;
      dividend_d  = N1'(num0);
      divisor_d   = inv0 ? D1'(1) : D1'(den0[31:0]);
    end else begin
      flags_d.inv = 1'b0;
      dividend_d  = pnz1_q ? N1'(pr1_q) : N1'(r1_q);
      divisor_d   = pnz1_q ? D1'(ps1_q) : D1'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dividend_o <= dividend_d;
    divisor_o  <= divisor_d;
    flags_o    <= flags_d;
  end

endmodule

`default_nettype wire

// ----- hdl/tdc_mid.sv -----
// ----------------------------------------------------------------------------
// Middle section of the conversion pipeline
// Saturates the first quotient for code-to-resistance and forms the second division over three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_mid #(
  parameter int unsigned RW = 32,
  parameter int unsigned N1 = 64,
  parameter int unsigned N2 = 64,
  parameter int unsigned D2 = 49
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tdc_pkg::cfg_t   cfg_i,
  input  wire logic            in_valid_i,
  input  wire logic [N1-1:0]   quotient_i,
  input  wire tdc_pkg::flags_t flags_i,
  output logic                 out_valid_o,
  output logic [N2-1:0]        dividend_o,
  output logic [D2-1:0]        divisor_o,
  output tdc_pkg::flags_t      flags_o
);

  logic [RW-1:0] series;
  logic [RW-1:0] parallel;
  assign series   = cfg_i.series[RW-1:0];
  assign parallel = cfg_i.parallel[RW-1:0];

  logic [2:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[2];

  tdc_pkg::flags_t f1_d, f1_q;
  logic [RW-1:0]   rnet1_d, rnet1_q;

  always_comb begin
    logic hi;
    hi      = |quotient_i[N1-1:RW];
    f1_d    = flags_i;
    rnet1_d = quotient_i[RW-1:0];
    if (flags_i.cmd == tdc_pkg::CMD_RES_FROM_CODE && hi) begin
      rnet1_d = '1;
      f1_d.sat = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q    <= f1_d;
    rnet1_q <= rnet1_d;
  end

  tdc_pkg::flags_t f2_d, f2_q;
  logic            pnz2_q;
  logic [2*RW-1:0] prod2_q;
  logic [RW-1:0]   diff2_q;
  logic [RW-1:0]   rnet2_q;
  logic [RW:0]     sum2_q;
  logic [RW+15:0]  fr2_q;

  always_comb begin
    f2_d = f1_q;
    if (f1_q.cmd == tdc_pkg::CMD_RES_FROM_CODE && parallel != '0 && rnet1_q >= parallel) begin
      f2_d.inv = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    f2_q    <= f2_d;
    pnz2_q  <= (parallel != '0);
    prod2_q <= (2*RW)'(rnet1_q) * (2*RW)'(parallel);
    diff2_q <= parallel - rnet1_q;
    rnet2_q <= rnet1_q;
    sum2_q  <= (RW+1)'(series) + (RW+1)'(rnet1_q);
    fr2_q   <= (RW+16)'(cfg_i.full_scale) * (RW+16)'(rnet1_q);
  end

  tdc_pkg::flags_t f3_d;
  logic [N2-1:0]   dividend_d;
  logic [D2-1:0]   divisor_d;

  always_comb begin
    logic [RW+16:0] den1;
    den1 = (RW+17)'(cfg_i.adc_ref) * (RW+17)'(sum2_q);
    f3_d = f2_q;
    if (f2_q.cmd == tdc_pkg::CMD_RES_FROM_CODE) begin
      dividend_d = pnz2_q ? N2'(prod2_q) : N2'(rnet2_q);
      divisor_d  = (pnz2_q && !f2_q.inv) ? D2'(diff2_q) : D2'(1);
    end else begin
      dividend_d = N2'((RW+32)'(fr2_q) * (RW+32)'(cfg_i.supply));
      divisor_d  = (den1 == '0) ? D2'(1) : D2'(den1);
      f3_d.inv   = (den1 == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    dividend_o <= dividend_d;
    divisor_o  <= divisor_d;
    flags_o    <= f3_d;
  end

endmodule

`default_nettype wire

// ----- hdl/thermistor_divider_conversion.sv -----
// ----------------------------------------------------------------------------
// Thermistor divider conversion
// Turns an ADC code into thermistor resistance, or a resistance into an ADC code.
// ----------------------------------------------------------------------------
// The block takes one request every clock cycle and never raises busy_o. Each
// result appears on the result ports for one cycle, marked by result_valid_o,
// and the receiver cannot hold it off. A request passes in order through the
// front end, the first divider pipeline, the middle section, the second divider
// pipeline and the output register. The two divider pipelines resolve one
// quotient bit per stage, with six surrounding register stages; the default
// widths give N1 = N2 = 64. Configuration writes are always ready and must
// be made only while no request is in flight.
`default_nettype none

module thermistor_divider_conversion #(
  parameter int unsigned RESISTANCE_WIDTH = tdc_pkg::RES_WIDTH,
  parameter int unsigned ADC_WIDTH        = tdc_pkg::ADC_WIDTH
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic                                 command_i,
  input  wire logic [15:0]                          adc_code_i,
  input  wire logic [31:0]                          resistance_in_i,
  output logic                                      result_valid_o,
  output logic [31:0]                               resistance_out_o,
  output logic [15:0]                               adc_code_out_o,
  output logic [1:0]                                status_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [tdc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  wire logic [tdc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i
);

  localparam int unsigned RW  = RESISTANCE_WIDTH;
  localparam int unsigned AW  = ADC_WIDTH;
  localparam int unsigned N1  = (RW + AW + 16 > 2 * RW) ? RW + AW + 16 : 2 * RW;
  localparam int unsigned D1  = (RW + 1 > 32) ? RW + 1 : 32;
  localparam int unsigned N2  = RW + 32;
  localparam int unsigned D2  = RW + 17;
  localparam int unsigned LAT = N1 + N2 + 6;
  localparam int unsigned SW  = $bits(tdc_pkg::flags_t);

  tdc_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.series     <= 32'd10000;
      cfg_q.parallel   <= '0;
      cfg_q.supply     <= 16'd3300;
      cfg_q.adc_ref    <= 16'd3300;
      cfg_q.full_scale <= 16'd4095;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tdc_pkg::REG_SERIES:     cfg_q.series     <= 32'(cfg_data_i[RW-1:0]);
        tdc_pkg::REG_PARALLEL:   cfg_q.parallel   <= 32'(cfg_data_i[RW-1:0]);
        tdc_pkg::REG_SUPPLY:     cfg_q.supply     <= cfg_data_i[15:0];
        tdc_pkg::REG_ADC_REF:    cfg_q.adc_ref    <= cfg_data_i[15:0];
        tdc_pkg::REG_FULL_SCALE: cfg_q.full_scale <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  logic            f_valid;
  logic [N1-1:0]   f_dividend;
  logic [D1-1:0]   f_divisor;
  tdc_pkg::flags_t f_flags;

  tdc_front #(
    .RW (RW),
    .AW (AW),
    .N1 (N1),
    .D1 (D1)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (start_i && !busy_o),
    .cmd_i       (command_i),
    .code_i      (adc_code_i[AW-1:0]),
    .res_i       (resistance_in_i[RW-1:0]),
    .out_valid_o (f_valid),
    .dividend_o  (f_dividend),
    .divisor_o   (f_divisor),
    .flags_o     (f_flags)
  );

  logic            d1_valid;
  logic [N1-1:0]   d1_quot;
  logic [SW-1:0]   d1_side;

  tdc_div #(
    .N  (N1),
    .D  (D1),
    .SW (SW)
  ) u_div1 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .dividend_i  (f_dividend),
    .divisor_i   (f_divisor),
    .side_i      (f_flags),
    .out_valid_o (d1_valid),
    .quotient_o  (d1_quot),
    .side_o      (d1_side)
  );

  logic            m_valid;
  logic [N2-1:0]   m_dividend;
  logic [D2-1:0]   m_divisor;
  tdc_pkg::flags_t m_flags;

  tdc_mid #(
    .RW (RW),
    .N1 (N1),
    .N2 (N2),
    .D2 (D2)
  ) u_mid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (d1_valid),
    .quotient_i  (d1_quot),
    .flags_i     (tdc_pkg::flags_t'(d1_side)),
    .out_valid_o (m_valid),
    .dividend_o  (m_dividend),
    .divisor_o   (m_divisor),
    .flags_o     (m_flags)
  );

  logic            d2_valid;
  logic [N2-1:0]   d2_quot;
  logic [SW-1:0]   d2_side;

  tdc_div #(
    .N  (N2),
    .D  (D2),
    .SW (SW)
  ) u_div2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (m_valid),
    .dividend_i  (m_dividend),
    .divisor_i   (m_divisor),
    .side_i      (m_flags),
    .out_valid_o (d2_valid),
    .quotient_o  (d2_quot),
    .side_o      (d2_side)
  );

  tdc_pkg::flags_t p_flags;
  logic [RW-1:0]   res_d;
  logic [AW-1:0]   code_d;
  logic [1:0]      status_d;

  assign p_flags = tdc_pkg::flags_t'(d2_side);

  always_comb begin
    logic hi_res;
    logic hi_code;
    hi_res   = |d2_quot[N2-1:RW];
    hi_code  = |d2_quot[N2-1:AW];
    res_d    = '0;
    code_d   = '0;
    status_d = tdc_pkg::ST_OK;
    if (p_flags.cmd == tdc_pkg::CMD_RES_FROM_CODE) begin
      if (p_flags.inv) begin
        res_d    = '1;
        status_d = tdc_pkg::ST_INVALID;
      end else if (hi_res) begin
        res_d    = '1;
        status_d = tdc_pkg::ST_SAT;
      end else begin
        res_d    = d2_quot[RW-1:0];
        status_d = p_flags.sat ? tdc_pkg::ST_SAT : tdc_pkg::ST_OK;
      end
    end else begin
      if (p_flags.inv) begin
        code_d   = '1;
        status_d = tdc_pkg::ST_INVALID;
      end else if (hi_code) begin
        code_d   = '1;
        status_d = tdc_pkg::ST_SAT;
      end else begin
        code_d   = d2_quot[AW-1:0];
      end
    end
  end

  logic          result_valid_q;
  logic [RW-1:0] res_q;
  logic [AW-1:0] code_q;
  logic [1:0]    status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    code_q   <= code_d;
    status_q <= status_d;
  end

  assign result_valid_o   = result_valid_q;
  assign resistance_out_o = 32'(res_q);
  assign adc_code_out_o   = 16'(code_q);
  assign status_o         = status_q;

  localparam logic [31:0] RES_ONES  = 32'((64'd1 << RW) - 64'd1);
  localparam logic [15:0] CODE_ONES = 16'((32'd1 << AW) - 32'd1);

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT result_valid_o)
    else $error("request did not produce a result at the pipeline latency");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (status_o == tdc_pkg::ST_OK || status_o == tdc_pkg::ST_INVALID ||
                        status_o == tdc_pkg::ST_SAT))
    else $error("result carries an undefined status");

  a_one_field : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (resistance_out_o == '0 || adc_code_out_o == '0))
    else $error("both result fields are active");

  a_invalid_ones : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == tdc_pkg::ST_INVALID) |->
      (resistance_out_o == RES_ONES || adc_code_out_o == CODE_ONES))
    else $error("invalid result is not all ones");

endmodule

`default_nettype wire
